@@ src/htcc_pkg.sv @@
`timescale 1ns / 1ps
package htcc_pkg;
    localparam int KeyUpperW = 64;
    localparam int KeyLowerW = 16;
    localparam int StepW = 16;
    localparam int ValueW = 64;
    localparam int CodeW = 20;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 64;
    localparam logic [StepW-1:0] StepReset = 16'd30;
    localparam logic [CodeW-1:0] CodeMod = 20'd1000000;
    // 10^6 shifted left by 11: largest multiple used when reducing a 31-bit value
    localparam logic [30:0] CodeModTop = 31'd2048000000;
    localparam logic [3:0] CodeModShift = 4'd11;
    localparam logic [7:0] Ipad = 8'h36;
    localparam logic [7:0] Opad = 8'h5c;

    localparam logic [1:0] CfgKeyUpper = 2'd0;
    localparam logic [1:0] CfgKeyLower = 2'd1;
    localparam logic [1:0] CfgTimeStep = 2'd2;
    localparam logic [1:0] CfgEpoch = 2'd3;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    typedef struct packed {
        logic         start;
        logic [511:0] block;
        logic         use_init;
    } t_sha_req;

    typedef struct packed {
        logic         done;
        logic [159:0] digest;
    } t_sha_rsp;
endpackage

@@ src/htcc_sha1_core.sv @@
`timescale 1ns / 1ps
// One SHA-1 compression, one round per cycle, 16-word schedule window.
module htcc_sha1_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  htcc_pkg::t_sha_req  i_req,
    output htcc_pkg::t_sha_rsp  o_rsp
);
    logic [511:0] r_w;
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [159:0] r_h;
    logic [6:0]   r_round;
    logic         r_busy;
    logic         r_done;

    logic [31:0] s_w0, s_f, s_k, s_t, s_wn;
    logic [159:0] s_hin;

    assign s_hin = i_req.use_init ?
        {htcc_pkg::H0, htcc_pkg::H1, htcc_pkg::H2, htcc_pkg::H3, htcc_pkg::H4} : r_h;
    assign s_w0 = r_w[511:480];

    // Pick round function and constant
    always_comb begin
        if (r_round < 7'd20) begin
            s_f = (r_b & r_c) | (~r_b & r_d);
            s_k = 32'h5A827999;
        end else if (r_round < 7'd40) begin
            s_f = r_b ^ r_c ^ r_d;
            s_k = 32'h6ED9EBA1;
        end else if (r_round < 7'd60) begin
            s_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            s_k = 32'h8F1BBCDC;
        end else begin
            s_f = r_b ^ r_c ^ r_d;
            s_k = 32'hCA62C1D6;
        end
    end

    logic [31:0] s_x;
    assign s_t  = {r_a[26:0], r_a[31:27]} + s_f + r_e + s_k + s_w0;
    assign s_x  = r_w[95:64] ^ r_w[255:224] ^ r_w[447:416] ^ r_w[511:480];
    assign s_wn = {s_x[30:0], s_x[31]};

    // Advance one round per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_round <= '0;
                r_w <= i_req.block;
                r_h <= s_hin;
                {r_a, r_b, r_c, r_d, r_e} <= s_hin;
            end else if (r_busy) begin
                r_a <= s_t;
                r_b <= r_a;
                r_c <= {r_b[1:0], r_b[31:2]};
                r_d <= r_c;
                r_e <= r_d;
                r_w <= {r_w[479:0], s_wn};
                if (r_round == 7'd79) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_h <= {r_h[159:128] + s_t, r_h[127:96] + r_a,
                            r_h[95:64] + {r_b[1:0], r_b[31:2]},
                            r_h[63:32] + r_c, r_h[31:0] + r_d};
                end
                r_round <= r_round + 7'd1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.digest = r_h;

`ifndef ASSERT_OFF
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_round == 7'd79) |=> r_done)
        else $error("done missing after last round");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done while busy");
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_round < 7'd80)
        else $error("round out of range");
`endif
endmodule

@@ src/htcc_divider.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module htcc_divider #(
    parameter int NumW = htcc_pkg::ValueW,
    parameter int DenW = htcc_pkg::StepW
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [NumW-1:0] i_num,
    input  logic [DenW-1:0] i_den,
    output logic            o_done,
    output logic [NumW-1:0] o_quot
);
    localparam int CntW = $clog2(NumW + 1);
    logic [NumW-1:0] r_q;
    logic [DenW-1:0] r_r, r_d;
    logic [CntW-1:0] r_cnt;
    logic            r_busy, r_done;
    logic [DenW:0]   s_trial;

    assign s_trial = {r_r, r_q[NumW-1]};

    // Shift in one numerator bit, subtract when it fits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_q <= i_num;
                r_r <= '0;
                r_d <= i_den;
                r_cnt <= CntW'(NumW);
            end else if (r_busy) begin
                if (s_trial >= {1'b0, r_d}) begin
                    r_r <= DenW'(s_trial - {1'b0, r_d});
                    r_q <= {r_q[NumW-2:0], 1'b1};
                end else begin
                    r_r <= s_trial[DenW-1:0];
                    r_q <= {r_q[NumW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

@@ src/hotp_totp_code_check.sv @@
`timescale 1ns / 1ps
// HOTP/TOTP six-digit code checker (HMAC-SHA1, 10-byte key). Raise start
// while busy is low; the item is taken at that edge and busy stays high
// until the result is out. One result appears on o_generated_code and
// o_code_match with o_result_valid high for exactly one cycle; it cannot be
// stalled, so the receiver must take it then. An HOTP item runs four SHA-1
// compressions on one shared round unit (load, 80 rounds, handoff), then the
// modulo 10^6 by compare and subtract of shifted multiples. TOTP first runs
// the counter division on a bit-serial divider. A new item can be taken at
// the edge that takes the result. A time step of zero acts as one; candidates
// above 999999 never match. Configuration writes are taken only while idle
// and start is low.
module hotp_totp_code_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cmd,
    input  logic [htcc_pkg::ValueW-1:0]   i_value,
    input  logic [htcc_pkg::CodeW-1:0]    i_candidate_code,
    output logic                          o_result_valid,
    output logic [htcc_pkg::CodeW-1:0]    o_generated_code,
    output logic                          o_code_match,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [htcc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [htcc_pkg::CfgDataW-1:0] i_cfg_data
);
    localparam logic [3:0] StIdle = 4'd0;
    localparam logic [3:0] StDiv  = 4'd1;
    localparam logic [3:0] StIn1  = 4'd2;
    localparam logic [3:0] StIn2  = 4'd3;
    localparam logic [3:0] StOut1 = 4'd4;
    localparam logic [3:0] StOut2 = 4'd5;
    localparam logic [3:0] StMod  = 4'd6;
    localparam logic [3:0] StOut  = 4'd7;

    logic [63:0] r_key_upper, r_epoch;
    logic [15:0] r_key_lower, r_step;
    logic [3:0]  r_state;
    logic        r_go;
    logic [63:0] r_counter;
    logic [19:0] r_cand, r_code;
    logic [159:0] r_inner;
    logic        r_match, r_valid;

    htcc_pkg::t_sha_req s_req;
    htcc_pkg::t_sha_rsp s_rsp;
    logic [511:0] s_kblk;
    logic [7:0]   s_pad;

    logic         s_dstart, s_ddone;
    logic [63:0]  s_dnum, s_dquot;
    logic [15:0]  s_dden;

    assign o_cfg_ready = (r_state == StIdle) && !start;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper <= '0;
            r_key_lower <= '0;
            r_step <= htcc_pkg::StepReset;
            r_epoch <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                htcc_pkg::CfgKeyUpper: r_key_upper <= i_cfg_data;
                htcc_pkg::CfgKeyLower: r_key_lower <= i_cfg_data[15:0];
                htcc_pkg::CfgTimeStep: r_step <= i_cfg_data[15:0];
                htcc_pkg::CfgEpoch:    r_epoch <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Key block xor pad
    assign s_pad = (r_state == StIn1) ? htcc_pkg::Ipad : htcc_pkg::Opad;
    assign s_kblk = {r_key_upper, r_key_lower, 432'd0} ^ {64{s_pad}};

    // Feed the shared SHA-1 unit
    always_comb begin
        s_req.start = r_go;
        s_req.use_init = (r_state == StIn1) || (r_state == StOut1);
        case (r_state)
            StIn2:  s_req.block = {r_counter, 8'h80, 376'd0, 64'd576};
            StOut2: s_req.block = {r_inner, 8'h80, 280'd0, 64'd672};
            default: s_req.block = s_kblk;
        endcase
    end

    htcc_sha1_core u_sha (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(s_req), .o_rsp(s_rsp)
    );

    // Dynamic truncation
    logic [3:0]   s_off;
    logic [159:0] s_sh;
    logic [30:0]  s_bin;
    assign s_off = s_rsp.digest[3:0];
    assign s_sh  = s_rsp.digest << {s_off, 3'b000};
    assign s_bin = s_sh[158:128];

    logic r_dgo;
    logic [63:0] r_dnum;
    logic [15:0] r_dden;
    assign s_dstart = r_dgo;
    assign s_dnum = r_dnum;
    assign s_dden = r_dden;

    htcc_divider #(.NumW(htcc_pkg::ValueW), .DenW(htcc_pkg::StepW)) u_div_t (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(s_dstart),
        .i_num(s_dnum), .i_den(s_dden), .o_done(s_ddone),
        .o_quot(s_dquot)
    );

    // Reduce modulo 10^6: subtract 10^6 * 2^k when it fits, k from 11 down to 0
    logic [30:0] r_rem, r_sub;
    logic [3:0]  r_mstep;
    logic        s_mfit;
    logic [30:0] s_mnext;
    assign s_mfit  = (r_rem >= r_sub);
    assign s_mnext = s_mfit ? (r_rem - r_sub) : r_rem;

    // Sequence one item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_go <= 1'b0;
            r_dgo <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_go <= 1'b0;
            r_dgo <= 1'b0;
            r_valid <= 1'b0;
            case (r_state)
                StIdle: if (start) begin
                    r_cand <= i_candidate_code;
                    if (i_cmd) begin
                        r_dnum <= i_value - r_epoch;
                        r_dden <= (r_step == '0) ? 16'd1 : r_step;
                        r_dgo <= 1'b1;
                        r_state <= StDiv;
                    end else begin
                        r_counter <= i_value;
                        r_go <= 1'b1;
                        r_state <= StIn1;
                    end
                end
                StDiv: if (s_ddone) begin
                    r_counter <= s_dquot;
                    r_go <= 1'b1;
                    r_state <= StIn1;
                end
                StIn1: if (s_rsp.done) begin r_go <= 1'b1; r_state <= StIn2; end
                StIn2: if (s_rsp.done) begin
                    r_inner <= s_rsp.digest;
                    r_go <= 1'b1;
                    r_state <= StOut1;
                end
                StOut1: if (s_rsp.done) begin r_go <= 1'b1; r_state <= StOut2; end
                StOut2: if (s_rsp.done) begin
                    r_rem <= s_bin;
                    r_sub <= htcc_pkg::CodeModTop;
                    r_mstep <= htcc_pkg::CodeModShift;
                    r_state <= StMod;
                end
                StMod: begin
                    r_rem <= s_mnext;
                    r_sub <= {1'b0, r_sub[30:1]};
                    r_mstep <= r_mstep - 4'd1;
                    if (r_mstep == 4'd0) begin
                        r_code <= s_mnext[19:0];
                        r_match <= (s_mnext[19:0] == r_cand);
                        r_valid <= 1'b1;
                        r_state <= StIdle;
                    end
                end
                default: r_state <= StIdle;
            endcase
        end
    end

    assign busy = (r_state != StIdle);
    assign o_result_valid = r_valid;
    assign o_generated_code = r_code;
    assign o_code_match = r_match;

`ifndef ASSERT_OFF
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_state == StIdle)
        else $error("result outside idle");
    a_match_cons: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_match == (r_code == r_cand)))
        else $error("match flag inconsistent");
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_code < htcc_pkg::CodeMod)
        else $error("code out of range");
`endif
endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    localparam int IdleLimit = 5000;
    localparam int DrainCycles = 60;
    localparam int RandomItems = 500;
    localparam int CodeW = htcc_pkg::CodeW;
    localparam int ValueW = htcc_pkg::ValueW;
    localparam int CfgIdxW = htcc_pkg::CfgIdxW;
    localparam int CfgDataW = htcc_pkg::CfgDataW;

    typedef struct packed {
        logic [CodeW-1:0] code;
        logic             match;
    } t_code_result;

    typedef struct {
        logic             cmd;
        logic [63:0]      value;
        logic [CodeW-1:0] cand;
        bit               cand_from_pred;
        bit               known_nomatch;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_cmd;
    logic [ValueW-1:0]    i_value;
    logic [CodeW-1:0]     i_candidate_code;
    logic                 o_result_valid;
    logic [CodeW-1:0]     o_generated_code;
    logic                 o_code_match;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CfgIdxW-1:0]   i_cfg_index;
    logic [CfgDataW-1:0]  i_cfg_data;

    // Local copy of the configuration registers
    logic [63:0] key_hi_q;
    logic [15:0] key_lo_q;
    logic [15:0] step_q;
    logic [63:0] epoch_q;

    t_code_result pending_codes[$];
    int err_count;
    int items_sent;
    int codes_checked;
    int matches_seen;
    int totp_items;
    int idle_cycles;

    hotp_totp_code_check i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_value          (i_value),
        .i_candidate_code (i_candidate_code),
        .o_result_valid   (o_result_valid),
        .o_generated_code (o_generated_code),
        .o_code_match     (o_code_match),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // One SHA-1 compression of a 512-bit block
    function automatic logic [159:0] sha1_compress(input logic [159:0] h,
                                                   input logic [511:0] blk);
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
        for (int i = 16; i < 80; i++) begin
            t = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
            w[i] = {t[30:0], t[31]};
        end
        {a, b, c, d, e} = h;
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i];
            e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
        end
        return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
    endfunction

    // HMAC-SHA1 over the counter, then dynamic truncation modulo 10^6
    function automatic logic [CodeW-1:0] otp_code(input logic [63:0] counter);
        logic [511:0] key_blk, pad_blk, tail_blk;
        logic [159:0] h, inner, mac;
        logic [31:0]  bin;
        logic [3:0]   off;
        key_blk = {key_hi_q, key_lo_q, 432'b0};
        pad_blk = key_blk ^ {64{8'h36}};
        tail_blk = {counter, 8'h80, 376'b0, 64'd576};
        h = sha1_compress({32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476,
                           32'hC3D2E1F0}, pad_blk);
        inner = sha1_compress(h, tail_blk);
        pad_blk = key_blk ^ {64{8'h5c}};
        tail_blk = {inner, 8'h80, 280'b0, 64'd672};
        h = sha1_compress({32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476,
                           32'hC3D2E1F0}, pad_blk);
        mac = sha1_compress(h, tail_blk);
        off = mac[3:0];
        bin = mac[159 - 8 * off -: 32] & 32'h7fffffff;
        return CodeW'(bin % 32'd1000000);
    endfunction

    function automatic logic [CodeW-1:0] predict_code(input logic cmd,
                                                      input logic [63:0] value);
        logic [63:0] step;
        if (!cmd) return otp_code(value);
        step = (step_q == 16'd0) ? 64'd1 : {48'd0, step_q};
        return otp_code((value - epoch_q) / step);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_code_result want;
        if (i_rst_n && o_result_valid) begin
            if (pending_codes.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_generated_code), 32'd0);
            end else begin
                want = pending_codes.pop_front();
                codes_checked++;
                if (o_code_match) matches_seen++;
                if (o_generated_code !== want.code)
                    report_mismatch("generated_code", 32'(o_generated_code),
                                    32'(want.code));
                if (o_code_match !== want.match)
                    report_mismatch("code_match", 32'(o_code_match), 32'(want.match));
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Write one register; call only while idle
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            htcc_pkg::CfgKeyUpper: key_hi_q = data;
            htcc_pkg::CfgKeyLower: key_lo_q = data[15:0];
            htcc_pkg::CfgTimeStep: step_q = data[15:0];
            htcc_pkg::CfgEpoch:    epoch_q = data;
            default: ;
        endcase
    endtask

    // Drain outstanding codes, then idle before returning
    task automatic wait_drained();
        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Present one item and hold it until taken; push its expected code
    task automatic send_check(input logic cmd, input logic [63:0] value,
                              input logic [CodeW-1:0] cand);
        t_code_result want;
        want.code = predict_code(cmd, value);
        want.match = (want.code == cand);
        i_cmd <= cmd;
        i_value <= value;
        i_candidate_code <= cand;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        pending_codes.push_back(want);
        items_sent++;
        if (cmd) totp_items++;
    endtask

    // Idle the sender between bursts
    int burst_left;
    task automatic maybe_gap();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            burst_left = $urandom_range(0, 6);
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    t_dir_row dir_rows[$];

    task automatic run_directed();
        logic [CodeW-1:0] cand;
        foreach (dir_rows[i]) begin
            cand = dir_rows[i].cand;
            if (dir_rows[i].cand_from_pred)
                cand = predict_code(dir_rows[i].cmd, dir_rows[i].value);
            if (dir_rows[i].known_nomatch && predict_code(dir_rows[i].cmd,
                    dir_rows[i].value) == cand)
                report_mismatch("out-of-range candidate predicted as match", 32'd1, 32'd0);
            send_check(dir_rows[i].cmd, dir_rows[i].value, cand);
            maybe_gap();
        end
        start <= 1'b0;
    endtask

    task automatic add_row(input logic cmd, input logic [63:0] value,
                           input logic [CodeW-1:0] cand, input bit from_pred,
                           input bit nomatch);
        t_dir_row r;
        r.cmd = cmd; r.value = value; r.cand = cand;
        r.cand_from_pred = from_pred; r.known_nomatch = nomatch;
        dir_rows.push_back(r);
    endtask

    // Random item: mostly in-range candidates; half of all items carry the right code
    task automatic send_random();
        logic             cmd;
        logic [63:0]      value;
        logic [CodeW-1:0] cand;
        cmd = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0: value = {32'd0, $urandom};
            1: value = epoch_q + {48'd0, 16'($urandom)};
            default: value = rand64();
        endcase
        case ($urandom_range(0, 7))
            0, 1, 2, 3: cand = predict_code(cmd, value);
            4: cand = CodeW'($urandom_range(1000000, 1048575));
            default: cand = CodeW'($urandom_range(0, 999999));
        endcase
        send_check(cmd, value, cand);
        maybe_gap();
    endtask

    initial begin
        err_count = 0; items_sent = 0; codes_checked = 0; matches_seen = 0;
        totp_items = 0; burst_left = 0; idle_cycles = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = 1'b0;
        i_value = '0;
        i_candidate_code = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = htcc_pkg::CfgKeyUpper;
        i_cfg_data = '0;
        key_hi_q = '0; key_lo_q = '0; step_q = htcc_pkg::StepReset; epoch_q = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: extremes of every field
        add_row(1'b0, 64'd0, 20'd0, 1'b0, 1'b0);
        add_row(1'b0, 64'hffff_ffff_ffff_ffff, 20'd999999, 1'b0, 1'b0);
        add_row(1'b0, 64'd1, 20'd0, 1'b1, 1'b0);
        add_row(1'b0, 64'd2, 20'd1000000, 1'b0, 1'b1);
        add_row(1'b0, 64'd3, 20'hfffff, 1'b0, 1'b1);
        add_row(1'b1, 64'd0, 20'd0, 1'b1, 1'b0);
        add_row(1'b1, 64'd59, 20'd0, 1'b1, 1'b0);
        add_row(1'b1, 64'hffff_ffff_ffff_ffff, 20'd0, 1'b1, 1'b0);
        add_row(1'b1, 64'haaaa_aaaa_5555_5555, 20'h55555, 1'b0, 1'b0);
        add_row(1'b0, 64'h5555_5555_aaaa_aaaa, 20'haaaaa, 1'b0, 1'b0);
        run_directed();
        wait_drained();

        // All-ones key, zero time step, epoch at or ahead of the time values
        write_reg(htcc_pkg::CfgKeyUpper, 64'hffff_ffff_ffff_ffff);
        write_reg(htcc_pkg::CfgKeyLower, 64'hffff_ffff_ffff_ffff);
        write_reg(htcc_pkg::CfgTimeStep, 64'd0);
        write_reg(htcc_pkg::CfgEpoch, 64'h8000_0000_0000_0000);
        dir_rows.delete();
        add_row(1'b1, 64'd100, 20'd0, 1'b1, 1'b0);
        add_row(1'b1, 64'd0, 20'd0, 1'b0, 1'b0);
        add_row(1'b1, 64'h7fff_ffff_ffff_ffff, 20'd999999, 1'b1, 1'b0);
        add_row(1'b1, 64'h8000_0000_0000_0000, 20'd1000000, 1'b0, 1'b1);
        add_row(1'b0, 64'd7, 20'd0, 1'b1, 1'b0);
        run_directed();
        wait_drained();

        // Largest step, epoch at the top, then step of one with a zero key
        write_reg(htcc_pkg::CfgTimeStep, 64'hffff_ffff_ffff_ffff);
        write_reg(htcc_pkg::CfgEpoch, 64'hffff_ffff_ffff_ffff);
        dir_rows.delete();
        add_row(1'b1, 64'd0, 20'd0, 1'b1, 1'b0);
        add_row(1'b1, 64'hffff_ffff_ffff_fffe, 20'd0, 1'b1, 1'b0);
        run_directed();
        wait_drained();
        write_reg(htcc_pkg::CfgTimeStep, 64'd1);
        write_reg(htcc_pkg::CfgKeyUpper, 64'd0);
        write_reg(htcc_pkg::CfgKeyLower, 64'd0);
        dir_rows.delete();
        add_row(1'b1, 64'd5, 20'd0, 1'b1, 1'b0);
        add_row(1'b0, 64'hffff_ffff_ffff_ffff, 20'd0, 1'b1, 1'b0);
        run_directed();
        wait_drained();

        // Random phases, each with a fresh configuration
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(htcc_pkg::CfgKeyUpper, rand64());
            write_reg(htcc_pkg::CfgKeyLower, rand64());
            case ($urandom_range(0, 4))
                0: write_reg(htcc_pkg::CfgTimeStep, 64'd0);
                1: write_reg(htcc_pkg::CfgTimeStep, 64'd65535);
                2: write_reg(htcc_pkg::CfgTimeStep, 64'd30);
                default: write_reg(htcc_pkg::CfgTimeStep, rand64());
            endcase
            write_reg(htcc_pkg::CfgEpoch, ($urandom_range(0, 2) == 0) ? 64'd0 : rand64());
            for (int n = 0; n < RandomItems / 10; n++) begin
                send_random();
                // Let the pipeline empty now and then
                if (n == 20 && ph % 3 == 0) begin
                    start <= 1'b0;
                    while (pending_codes.size() != 0) @(posedge i_clk);
                end
            end
            start <= 1'b0;
            wait_drained();
        end

        repeat (DrainCycles) @(posedge i_clk);
        $display("Checked %0d codes over %0d items (%0d TOTP), %0d matches, 14 settings",
                 codes_checked, items_sent, totp_items, matches_seen);
        if (err_count == 0 && pending_codes.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
